@@ rtl/core/nph_pkg.sv @@
// Shared types, command codes and character helpers for the nucleotide
// position histogram. No dependencies; the interfaces and the top level import it.
`timescale 1ns / 1ps

package nph_pkg;

  // Payload widths of the two channels.
  localparam int CMD_W    = 2;
  localparam int SYMBOL_W = 8;
  localparam int MIDX_IN_W = 7;
  localparam int VALUE_W  = 32;
  localparam int SLOT_W   = 6;

  typedef logic [CMD_W-1:0]    cmd_t;
  typedef logic [SYMBOL_W-1:0] symbol_t;

  // Command codes.
  localparam cmd_t CMD_CHAR   = 2'd0;
  localparam cmd_t CMD_EMPTY  = 2'd1;
  localparam cmd_t CMD_REPORT = 2'd2;
  localparam cmd_t CMD_READ   = 2'd3;

  // Letters that are counted, and the whitespace codes.
  localparam symbol_t CHAR_A = 8'h41;
  localparam symbol_t CHAR_C = 8'h43;
  localparam symbol_t CHAR_G = 8'h47;
  localparam symbol_t CHAR_T = 8'h54;
  localparam symbol_t CHAR_TAB   = 8'd9;
  localparam symbol_t CHAR_CR    = 8'd13;
  localparam symbol_t CHAR_SPACE = 8'd32;

  // Slot of the first length bin in the report, after the four totals.
  localparam int HIST_BASE = 4;

  typedef struct packed {
    logic       ok;
    logic [1:0] code;
  } base_t;

  // Whitespace: tab through carriage return, or space.
  function automatic logic is_blank(input symbol_t c);
    return c inside {[CHAR_TAB:CHAR_CR], CHAR_SPACE};
  endfunction

  // Maps A, C, G, T to 0..3; ok is low for any other symbol.
  function automatic base_t base_code(input symbol_t c);
    base_t r;
    r.ok   = 1'b1;
    r.code = 2'd0;
    case (c)
      CHAR_A:  r.code = 2'd0;
      CHAR_C:  r.code = 2'd1;
      CHAR_G:  r.code = 2'd2;
      CHAR_T:  r.code = 2'd3;
      default: r.ok = 1'b0;
    endcase
    return r;
  endfunction

endpackage

@@ rtl/core/nph_in_if.sv @@
// Input channel of the nucleotide position histogram: valid/ready plus
// one command item. Depends on nph_pkg for the field widths.
`timescale 1ns / 1ps

interface nph_in_if import nph_pkg::*; ();
  logic                 valid;
  logic                 ready;
  cmd_t                 cmd;
  symbol_t              symbol;
  logic                 end_of_sequence;
  logic [MIDX_IN_W-1:0] matrix_index;

  modport source (output valid, cmd, symbol, end_of_sequence, matrix_index,
                  input ready);
  modport sink   (input valid, cmd, symbol, end_of_sequence, matrix_index,
                  output ready);
endinterface

@@ rtl/core/nph_out_if.sv @@
// Result channel of the nucleotide position histogram: valid/ready plus
// one result item. Depends on nph_pkg for the field widths.
`timescale 1ns / 1ps

interface nph_out_if import nph_pkg::*; ();
  logic               valid;
  logic               ready;
  logic [VALUE_W-1:0] value;
  logic [SLOT_W-1:0]  item_index;
  logic               last;

  modport source (output valid, value, item_index, last, input ready);
  modport sink   (input valid, value, item_index, last, output ready);
endinterface

@@ rtl/core/nph_ram.sv @@
// Generic single-write, single-read synchronous RAM with a registered read.
// No dependencies.
`timescale 1ns / 1ps

module nph_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 120
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  // Write port and registered read port.
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

@@ rtl/core/nucleotide_position_histogram.sv @@
// Top level of the nucleotide position histogram.
// Depends on nph_pkg, nph_in_if, nph_out_if and nph_ram.
`timescale 1ns / 1ps

// Usage
// The input channel carries one command per transfer: a sequence character,
// an empty sequence, an end-of-batch report or a matrix read. The result
// channel carries value, report slot and a last flag.
// The per-position matrix sits in one RAM, the batch totals and length bins
// in a second RAM (slots in report order). Every update is a read, modify
// and write of one entry; the sequencer takes no new command until its
// writes are done, so accesses to one entry never overlap.
// Sequencing: a character with no batch update is taken in S_IDLE alone; else
// it passes S_RMW1 and, when it both updates a total and closes a sequence,
// S_RMW2 (one batch RAM update in each, up to two per character); an empty
// sequence passes S_RMW1. A read passes S_READ, which loads the output register.
// A report walks the batch RAM through S_REP_WAIT and S_REP_OUT per slot, then sends the mode.
// A stalled receiver holds the output register; the walk waits there, and
// character commands are still taken while a finished result waits.
// Reset clears the valid bits of both RAMs at once (an entry that is not
// valid reads as zero), the sequence position and the output valid flag.
// No clearing pass is needed; a report clears the batch valid bits.
module nucleotide_position_histogram import nph_pkg::*; #(
  parameter int MAX_LEN    = 30,
  parameter int COUNT_BITS = 32
) (
  input  logic     clk,
  input  logic     rst_n,
  nph_in_if.sink   in_ch,
  nph_out_if.source out_ch
);

  localparam int NCELLS = 4 * MAX_LEN;
  localparam int BDEPTH = HIST_BASE + MAX_LEN + 1;
  localparam int MIDX_W = $clog2(NCELLS);
  localparam int BIDX_W = $clog2(BDEPTH);
  localparam int POS_W  = $clog2(MAX_LEN + 1);

  // Sequencer states.
  localparam logic [2:0] S_IDLE     = 3'd0;
  localparam logic [2:0] S_RMW1     = 3'd1;
  localparam logic [2:0] S_RMW2     = 3'd2;
  localparam logic [2:0] S_READ     = 3'd3;
  localparam logic [2:0] S_REP_WAIT = 3'd4;
  localparam logic [2:0] S_REP_OUT  = 3'd5;
  localparam logic [2:0] S_REP_MODE = 3'd6;

  typedef logic [COUNT_BITS-1:0] count_t;

  logic [2:0]        state_r, state_nxt;
  logic [POS_W-1:0]  pos_r, pos_nxt;
  logic [NCELLS-1:0] m_valid_r, m_valid_nxt;
  logic [BDEPTH-1:0] b_valid_r, b_valid_nxt;
  logic [MIDX_W-1:0] m_addr_r, m_addr_nxt;
  logic              m_op_r, m_op_nxt;
  logic              m_inrange_r, m_inrange_nxt;
  logic [BIDX_W-1:0] ba_r, ba_nxt;
  logic [BIDX_W-1:0] op2_addr_r, op2_addr_nxt;
  logic              op2_r, op2_nxt;
  count_t            best_r, best_nxt;
  logic [POS_W-1:0]  mode_r, mode_nxt;

  logic               out_valid_r, out_valid_nxt;
  logic [VALUE_W-1:0] out_value_r, out_value_nxt;
  logic [SLOT_W-1:0]  out_slot_r, out_slot_nxt;
  logic               out_last_r, out_last_nxt;
  logic               out_load, out_free;

  logic              in_xfer;
  base_t             base;
  logic              blank_first;
  logic [POS_W-1:0]  pos_inc;
  logic              op1_en;
  logic [BIDX_W-1:0] op1_addr, hist_len_addr;

  logic              m_we, b_we;
  logic [MIDX_W-1:0] m_raddr, char_maddr, read_maddr;
  logic [BIDX_W-1:0] b_raddr, first_addr;
  count_t            m_rdata, b_rdata, m_cur, b_cur, m_wdata, b_wdata;

  assign in_ch.ready = (state_r == S_IDLE);
  assign in_xfer     = in_ch.valid && in_ch.ready;
  assign out_free    = !out_valid_r || out_ch.ready;

  // Decode of a character command.
  assign base        = base_code(in_ch.symbol);
  assign blank_first = (pos_r == '0) && is_blank(in_ch.symbol);
  assign pos_inc     = (pos_r < POS_W'(MAX_LEN)) ? pos_r + POS_W'(1) : pos_r;
  assign op1_en      = blank_first || base.ok;
  assign op1_addr    = base.ok ? BIDX_W'(base.code) : BIDX_W'(HIST_BASE);
  assign hist_len_addr = BIDX_W'(HIST_BASE) + BIDX_W'(pos_inc);
  assign char_maddr  = MIDX_W'(32'(base.code) * MAX_LEN + 32'(pos_r));
  assign read_maddr  = MIDX_W'(in_ch.matrix_index);

  // First batch entry to update for the command on the input.
  always_comb begin
    if (in_ch.cmd == CMD_EMPTY) begin
      first_addr = BIDX_W'(HIST_BASE);
    end else if (op1_en) begin
      first_addr = op1_addr;
    end else begin
      first_addr = hist_len_addr;
    end
  end

  // Read address selection for both RAMs.
  always_comb begin
    if (state_r == S_IDLE) begin
      b_raddr = first_addr;
      m_raddr = (in_ch.cmd == CMD_READ) ? read_maddr : char_maddr;
    end else if (state_r == S_RMW1) begin
      b_raddr = op2_addr_r;
      m_raddr = m_addr_r;
    end else begin
      b_raddr = ba_r;
      m_raddr = m_addr_r;
    end
  end

  // Read, modify and write data paths.
  assign m_cur   = m_valid_r[m_addr_r] ? m_rdata : '0;
  assign b_cur   = b_valid_r[ba_r] ? b_rdata : '0;
  assign m_wdata = m_cur + COUNT_BITS'(1);
  assign b_wdata = b_cur + COUNT_BITS'(1);
  assign m_we    = (state_r == S_RMW1) && m_op_r;
  assign b_we    = (state_r == S_RMW1) || (state_r == S_RMW2);

  nph_ram #(.WIDTH(COUNT_BITS), .DEPTH(NCELLS)) u_matrix_ram (
    .clk   (clk),
    .we    (m_we),
    .waddr (m_addr_r),
    .wdata (m_wdata),
    .raddr (m_raddr),
    .rdata (m_rdata)
  );

  nph_ram #(.WIDTH(COUNT_BITS), .DEPTH(BDEPTH)) u_batch_ram (
    .clk   (clk),
    .we    (b_we),
    .waddr (ba_r),
    .wdata (b_wdata),
    .raddr (b_raddr),
    .rdata (b_rdata)
  );

  // Sequencer.
  always_comb begin
    state_nxt     = state_r;
    pos_nxt       = pos_r;
    m_valid_nxt   = m_valid_r;
    b_valid_nxt   = b_valid_r;
    m_addr_nxt    = m_addr_r;
    m_op_nxt      = m_op_r;
    m_inrange_nxt = m_inrange_r;
    ba_nxt        = ba_r;
    op2_addr_nxt  = op2_addr_r;
    op2_nxt       = op2_r;
    best_nxt      = best_r;
    mode_nxt      = mode_r;
    out_load      = 1'b0;
    out_value_nxt = out_value_r;
    out_slot_nxt  = out_slot_r;
    out_last_nxt  = out_last_r;

    case (state_r)
      S_IDLE: begin
        if (in_xfer) begin
          case (in_ch.cmd)
            CMD_CHAR: begin
              m_addr_nxt   = char_maddr;
              m_op_nxt     = base.ok && (pos_r < POS_W'(MAX_LEN));
              ba_nxt       = first_addr;
              op2_addr_nxt = hist_len_addr;
              op2_nxt      = op1_en && in_ch.end_of_sequence;
              pos_nxt      = in_ch.end_of_sequence ? '0 : pos_inc;
              if (op1_en || in_ch.end_of_sequence) begin
                state_nxt = S_RMW1;
              end
            end
            CMD_EMPTY: begin
              m_op_nxt  = 1'b0;
              ba_nxt    = first_addr;
              op2_nxt   = 1'b0;
              state_nxt = S_RMW1;
            end
            CMD_REPORT: begin
              ba_nxt    = '0;
              best_nxt  = '0;
              mode_nxt  = '0;
              state_nxt = S_REP_WAIT;
            end
            default: begin
              m_addr_nxt    = read_maddr;
              m_inrange_nxt = (32'(in_ch.matrix_index) < NCELLS);
              state_nxt     = S_READ;
            end
          endcase
        end
      end
      S_RMW1: begin
        // First batch update, and the matrix update of a counted letter.
        b_valid_nxt[ba_r] = 1'b1;
        if (m_op_r) begin
          m_valid_nxt[m_addr_r] = 1'b1;
        end
        ba_nxt    = op2_addr_r;
        state_nxt = op2_r ? S_RMW2 : S_IDLE;
      end
      S_RMW2: begin
        // Length bin of a sequence that just ended.
        b_valid_nxt[ba_r] = 1'b1;
        state_nxt         = S_IDLE;
      end
      S_READ: begin
        if (out_free) begin
          out_load      = 1'b1;
          out_value_nxt = m_inrange_r ? VALUE_W'(m_cur) : '0;
          out_slot_nxt  = '0;
          out_last_nxt  = 1'b1;
          state_nxt     = S_IDLE;
        end
      end
      S_REP_WAIT: begin
        state_nxt = S_REP_OUT;
      end
      S_REP_OUT: begin
        if (out_free) begin
          out_load      = 1'b1;
          out_value_nxt = VALUE_W'(b_cur);
          out_slot_nxt  = SLOT_W'(ba_r);
          out_last_nxt  = 1'b0;
          // Mode tracking over the length bins; ties go to the larger length.
          if (ba_r >= BIDX_W'(HIST_BASE)) begin
            if (b_cur > best_r) begin
              best_nxt = b_cur;
            end
            if (b_cur >= best_r) begin
              mode_nxt = POS_W'(ba_r - BIDX_W'(HIST_BASE));
            end
          end
          if (ba_r == BIDX_W'(BDEPTH - 1)) begin
            state_nxt = S_REP_MODE;
          end else begin
            ba_nxt    = ba_r + BIDX_W'(1);
            state_nxt = S_REP_WAIT;
          end
        end
      end
      S_REP_MODE: begin
        if (out_free) begin
          out_load      = 1'b1;
          out_value_nxt = VALUE_W'(mode_r);
          out_slot_nxt  = SLOT_W'(BDEPTH);
          out_last_nxt  = 1'b1;
          b_valid_nxt   = '0;
          state_nxt     = S_IDLE;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  // Output register valid flag.
  always_comb begin
    if (out_load) begin
      out_valid_nxt = 1'b1;
    end else if (out_ch.ready) begin
      out_valid_nxt = 1'b0;
    end else begin
      out_valid_nxt = out_valid_r;
    end
  end

  // Control state.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      pos_r       <= '0;
      m_valid_r   <= '0;
      b_valid_r   <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      pos_r       <= pos_nxt;
      m_valid_r   <= m_valid_nxt;
      b_valid_r   <= b_valid_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  // Working registers and result payload.
  always_ff @(posedge clk) begin
    m_addr_r    <= m_addr_nxt;
    m_op_r      <= m_op_nxt;
    m_inrange_r <= m_inrange_nxt;
    ba_r        <= ba_nxt;
    op2_addr_r  <= op2_addr_nxt;
    op2_r       <= op2_nxt;
    best_r      <= best_nxt;
    mode_r      <= mode_nxt;
    out_value_r <= out_value_nxt;
    out_slot_r  <= out_slot_nxt;
    out_last_r  <= out_last_nxt;
  end

  assign out_ch.valid      = out_valid_r;
  assign out_ch.value      = out_value_r;
  assign out_ch.item_index = out_slot_r;
  assign out_ch.last       = out_last_r;

  // The sequence position never passes the saturation length.
  a_pos_range: assert property (@(posedge clk) disable iff (!rst_n)
    pos_r <= POS_W'(MAX_LEN))
    else $error("sequence position beyond MAX_LEN");

  // Batch writes stay inside the batch RAM.
  a_batch_addr: assert property (@(posedge clk) disable iff (!rst_n)
    b_we |-> (32'(ba_r) < BDEPTH))
    else $error("batch write address out of range");

  // A result marked last comes only from a read or the end of a report.
  a_last_src: assert property (@(posedge clk) disable iff (!rst_n)
    (out_load && out_last_nxt) |-> (state_r == S_READ || state_r == S_REP_MODE))
    else $error("last flag from an unexpected state");

  // Once the mode is loaded, the batch counters read as cleared.
  a_batch_clear: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_REP_MODE && out_free) |=> (b_valid_r == '0))
    else $error("batch counters not cleared after report");

endmodule
